/* hw/rtl/tsm_pkg.sv */
package tsm_pkg;

  localparam int TIME_WIDTH   = 64;
  localparam int DATA_WIDTH   = 64;
  localparam int BYTES_WIDTH  = 32;
  localparam int LEVEL_WIDTH  = 16;
  localparam int LAT_IN_WIDTH = 32;
  localparam int INDEX_WIDTH  = 4;

  localparam int COUNTER_WIDTH_DEFAULT        = 64;
  localparam int LATENCY_WIDTH_DEFAULT        = 32;
  localparam int JITTER_FRACTION_BITS_DEFAULT = 4;

  // Jitter filter gain is 1/16
  localparam int JITTER_GAIN_SHIFT = 4;

  typedef enum logic [1:0] {
    OP_SEND        = 2'd0,
    OP_RECEIVE     = 2'd1,
    OP_FIFO_SAMPLE = 2'd2,
    OP_READ        = 2'd3
  } op_t;

  typedef enum logic [INDEX_WIDTH-1:0] {
    IDX_STARTED             = 4'd0,
    IDX_START_TIME          = 4'd1,
    IDX_CURRENT_TIME        = 4'd2,
    IDX_SENT_COUNT          = 4'd3,
    IDX_RECEIVED_COUNT      = 4'd4,
    IDX_BYTES_SENT          = 4'd5,
    IDX_BYTES_RECEIVED      = 4'd6,
    IDX_LATENCY_SUM         = 4'd7,
    IDX_JITTER_ESTIMATE     = 4'd8,
    IDX_UNDERRUN_COUNT      = 4'd9,
    IDX_OVERRUN_COUNT       = 4'd10,
    IDX_OUTSTANDING_SUM     = 4'd11,
    IDX_OUTSTANDING_SAMPLES = 4'd12,
    IDX_FIFO_LEVEL_SUM      = 4'd13,
    IDX_FIFO_SAMPLES        = 4'd14,
    IDX_PREVIOUS_LATENCY    = 4'd15
  } index_t;

  typedef struct packed {
    op_t                     operation;
    logic [TIME_WIDTH-1:0]   timestamp;
    logic [BYTES_WIDTH-1:0]  byte_count;
    logic [LEVEL_WIDTH-1:0]  outstanding;
    logic [LAT_IN_WIDTH-1:0] response_latency;
    logic [LEVEL_WIDTH-1:0]  fifo_level;
    logic                    underrun_flag;
    logic                    overrun_flag;
    index_t                  counter_index;
  } item_t;

endpackage

/* hw/rtl/tsm_if.sv */
interface tsm_item_if import tsm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  op_t                     operation;
  logic [TIME_WIDTH-1:0]   timestamp;
  logic [BYTES_WIDTH-1:0]  byte_count;
  logic [LEVEL_WIDTH-1:0]  outstanding;
  logic [LAT_IN_WIDTH-1:0] response_latency;
  logic [LEVEL_WIDTH-1:0]  fifo_level;
  logic                    underrun_flag;
  logic                    overrun_flag;
  logic [INDEX_WIDTH-1:0]  counter_index;

  modport source (
    output valid, operation, timestamp, byte_count, outstanding, response_latency,
           fifo_level, underrun_flag, overrun_flag, counter_index,
    input  ready
  );
  modport sink (
    input  valid, operation, timestamp, byte_count, outstanding, response_latency,
           fifo_level, underrun_flag, overrun_flag, counter_index,
    output ready
  );
endinterface

interface tsm_result_if import tsm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink (input valid, read_data, output ready);
endinterface

/* hw/rtl/traffic_statistics_monitor_unit.sv */
// A read transfer on item is held in the input register and then in the result
// register, which drives result. Throughput: one item per cycle; a read waits only
// while an earlier result is held on result, and the single input register and
// result register set this. Reset (rst, synchronous): all counters and sums clear,
// start_time goes to all ones, the input and result registers empty.
module traffic_statistics_monitor_unit import tsm_pkg::*; #(
  parameter int COUNTER_WIDTH        = COUNTER_WIDTH_DEFAULT,
  parameter int LATENCY_WIDTH        = LATENCY_WIDTH_DEFAULT,
  parameter int JITTER_FRACTION_BITS = JITTER_FRACTION_BITS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  tsm_item_if.sink     item,
  tsm_result_if.source result
);

  item_t                 item_in;
  logic                  stage_valid;
  item_t                 stage_item;
  logic                  stage_go;
  logic                  stage_read;
  logic                  res_valid;
  logic [DATA_WIDTH-1:0] res_data;
  logic [DATA_WIDTH-1:0] read_value;

  always_comb begin
    item_in.operation        = item.operation;
    item_in.timestamp        = item.timestamp;
    item_in.byte_count       = item.byte_count;
    item_in.outstanding      = item.outstanding;
    item_in.response_latency = item.response_latency;
    item_in.fifo_level       = item.fifo_level;
    item_in.underrun_flag    = item.underrun_flag;
    item_in.overrun_flag     = item.overrun_flag;
    item_in.counter_index    = index_t'(item.counter_index);
  end

  // only a read needs room in the result register
  assign stage_read = stage_item.operation == OP_READ;
  assign stage_go   = stage_valid && (!stage_read || !res_valid || result.ready);
  assign item.ready = !stage_valid || stage_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item.ready) begin
      stage_valid <= item.valid;
    end
    if (item.ready && item.valid) begin
      stage_item <= item_in;
    end
  end

  tsm_counters #(
    .COUNTER_WIDTH        (COUNTER_WIDTH),
    .LATENCY_WIDTH        (LATENCY_WIDTH),
    .JITTER_FRACTION_BITS (JITTER_FRACTION_BITS)
  ) u_counters (
    .clk        (clk),
    .rst        (rst),
    .update     (stage_go),
    .item       (stage_item),
    .read_value (read_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (stage_go && stage_read) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
    if (stage_go && stage_read) begin
      res_data <= read_value;
    end
  end

  assign result.valid     = res_valid;
  assign result.read_data = res_data;

endmodule

/* hw/rtl/tsm_jitter.sv */
module tsm_jitter import tsm_pkg::*; #(
  parameter int LATENCY_WIDTH        = LATENCY_WIDTH_DEFAULT,
  parameter int JITTER_FRACTION_BITS = JITTER_FRACTION_BITS_DEFAULT
) (
  input  logic [LATENCY_WIDTH-1:0]                      latency,
  input  logic [LATENCY_WIDTH-1:0]                      previous_latency,
  input  logic [LATENCY_WIDTH+JITTER_FRACTION_BITS-1:0] jitter,
  output logic [LATENCY_WIDTH+JITTER_FRACTION_BITS-1:0] jitter_next
);

  localparam int JW = LATENCY_WIDTH + JITTER_FRACTION_BITS;
  localparam logic [JW:0] GAIN_ROUND = (JW+1)'((1 << JITTER_GAIN_SHIFT) - 1);

  logic [LATENCY_WIDTH-1:0] diff;
  logic [JW-1:0]            target;
  logic [JW-1:0]            rise;
  logic [JW:0]              down_span;
  logic [JW-1:0]            fall;

  always_comb begin
    diff      = (latency >= previous_latency) ? latency - previous_latency
                                              : previous_latency - latency;
    target    = {diff, {JITTER_FRACTION_BITS{1'b0}}};
    rise      = (target - jitter) >> JITTER_GAIN_SHIFT;
    // round the downward step up so the estimate lands on the floor
    down_span = {1'b0, jitter} - {1'b0, target} + GAIN_ROUND;
    fall      = JW'(down_span >> JITTER_GAIN_SHIFT);
    if (target >= jitter) begin
      jitter_next = jitter + rise;
    end else begin
      jitter_next = jitter - fall;
    end
  end

endmodule

/* hw/rtl/tsm_counters.sv */
module tsm_counters import tsm_pkg::*; #(
  parameter int COUNTER_WIDTH        = COUNTER_WIDTH_DEFAULT,
  parameter int LATENCY_WIDTH        = LATENCY_WIDTH_DEFAULT,
  parameter int JITTER_FRACTION_BITS = JITTER_FRACTION_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  update,
  input  item_t                 item,
  output logic [DATA_WIDTH-1:0] read_value
);

  localparam int JW = LATENCY_WIDTH + JITTER_FRACTION_BITS;

  logic                     started;
  logic [TIME_WIDTH-1:0]    start_time;
  logic [TIME_WIDTH-1:0]    current_time;
  logic [COUNTER_WIDTH-1:0] sent_count;
  logic [COUNTER_WIDTH-1:0] received_count;
  logic [COUNTER_WIDTH-1:0] bytes_sent;
  logic [COUNTER_WIDTH-1:0] bytes_received;
  logic [COUNTER_WIDTH-1:0] latency_sum;
  logic [JW-1:0]            jitter_estimate;
  logic [COUNTER_WIDTH-1:0] underrun_count;
  logic [COUNTER_WIDTH-1:0] overrun_count;
  logic [COUNTER_WIDTH-1:0] outstanding_sum;
  logic [COUNTER_WIDTH-1:0] outstanding_samples;
  logic [COUNTER_WIDTH-1:0] fifo_level_sum;
  logic [COUNTER_WIDTH-1:0] fifo_samples;
  logic [LATENCY_WIDTH-1:0] previous_latency;

  logic [LATENCY_WIDTH-1:0] latency;
  logic [JW-1:0]            jitter_next;
  logic                     timed;

  assign latency = LATENCY_WIDTH'(item.response_latency);
  assign timed   = (item.operation == OP_SEND) || (item.operation == OP_RECEIVE);

  tsm_jitter #(
    .LATENCY_WIDTH        (LATENCY_WIDTH),
    .JITTER_FRACTION_BITS (JITTER_FRACTION_BITS)
  ) u_jitter (
    .latency          (latency),
    .previous_latency (previous_latency),
    .jitter           (jitter_estimate),
    .jitter_next      (jitter_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      started             <= 1'b0;
      start_time          <= '1;
      current_time        <= '0;
      sent_count          <= '0;
      received_count      <= '0;
      bytes_sent          <= '0;
      bytes_received      <= '0;
      latency_sum         <= '0;
      jitter_estimate     <= '0;
      underrun_count      <= '0;
      overrun_count       <= '0;
      outstanding_sum     <= '0;
      outstanding_samples <= '0;
      fifo_level_sum      <= '0;
      fifo_samples        <= '0;
      previous_latency    <= '0;
    end else if (update) begin
      if (timed) begin
        if (!started) begin
          started    <= 1'b1;
          start_time <= item.timestamp;
        end
        // time never moves backward
        if (item.timestamp >= current_time) begin
          current_time <= item.timestamp;
        end
      end
      unique case (item.operation)
        OP_SEND: begin
          sent_count          <= sent_count + 1'b1;
          bytes_sent          <= bytes_sent + COUNTER_WIDTH'(item.byte_count);
          outstanding_sum     <= outstanding_sum + COUNTER_WIDTH'(item.outstanding);
          outstanding_samples <= outstanding_samples + 1'b1;
        end
        OP_RECEIVE: begin
          received_count   <= received_count + 1'b1;
          bytes_received   <= bytes_received + COUNTER_WIDTH'(item.byte_count);
          jitter_estimate  <= jitter_next;
          previous_latency <= latency;
          latency_sum      <= latency_sum + COUNTER_WIDTH'(latency);
        end
        OP_FIFO_SAMPLE: begin
          fifo_level_sum <= fifo_level_sum + COUNTER_WIDTH'(item.fifo_level);
          fifo_samples   <= fifo_samples + 1'b1;
          if (item.underrun_flag) begin
            underrun_count <= underrun_count + 1'b1;
          end
          if (item.overrun_flag) begin
            overrun_count <= overrun_count + 1'b1;
          end
        end
        OP_READ: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (item.counter_index)
      IDX_STARTED:             read_value = DATA_WIDTH'(started);
      IDX_START_TIME:          read_value = DATA_WIDTH'(start_time);
      IDX_CURRENT_TIME:        read_value = DATA_WIDTH'(current_time);
      IDX_SENT_COUNT:          read_value = DATA_WIDTH'(sent_count);
      IDX_RECEIVED_COUNT:      read_value = DATA_WIDTH'(received_count);
      IDX_BYTES_SENT:          read_value = DATA_WIDTH'(bytes_sent);
      IDX_BYTES_RECEIVED:      read_value = DATA_WIDTH'(bytes_received);
      IDX_LATENCY_SUM:         read_value = DATA_WIDTH'(latency_sum);
      IDX_JITTER_ESTIMATE:     read_value = DATA_WIDTH'(jitter_estimate);
      IDX_UNDERRUN_COUNT:      read_value = DATA_WIDTH'(underrun_count);
      IDX_OVERRUN_COUNT:       read_value = DATA_WIDTH'(overrun_count);
      IDX_OUTSTANDING_SUM:     read_value = DATA_WIDTH'(outstanding_sum);
      IDX_OUTSTANDING_SAMPLES: read_value = DATA_WIDTH'(outstanding_samples);
      IDX_FIFO_LEVEL_SUM:      read_value = DATA_WIDTH'(fifo_level_sum);
      IDX_FIFO_SAMPLES:        read_value = DATA_WIDTH'(fifo_samples);
      IDX_PREVIOUS_LATENCY:    read_value = DATA_WIDTH'(previous_latency);
      default:                 read_value = '0;
    endcase
  end

endmodule

/* hw/rtl/tsm_checker.sv */
module tsm_checker import tsm_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  item_valid,
  input logic                  item_ready,
  input op_t                   item_operation,
  input logic                  result_valid,
  input logic                  result_ready,
  input logic [DATA_WIDTH-1:0] result_read_data
);

  a_reset_empties: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> item_ready)
    else $error("item not ready while no result is held");

  a_result_from_read: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |->
      $past(item_valid && item_ready && item_operation == OP_READ, 2))
    else $error("result appeared without a read two cycles earlier");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_read_data))
    else $error("stalled result changed");

endmodule

bind traffic_statistics_monitor_unit tsm_checker u_checker (
  .clk              (clk),
  .rst              (rst),
  .item_valid       (item.valid),
  .item_ready       (item.ready),
  .item_operation   (item.operation),
  .result_valid     (result.valid),
  .result_ready     (result.ready),
  .result_read_data (result.read_data)
);

/* verif/traffic_statistics_monitor_unit_tb.sv */
`timescale 1ns / 1ps

module traffic_statistics_monitor_unit_tb;
  import tsm_pkg::*;

  localparam int CNT_W = COUNTER_WIDTH_DEFAULT;
  localparam int LAT_W = LATENCY_WIDTH_DEFAULT;
  localparam int JIT_W = LATENCY_WIDTH_DEFAULT + JITTER_FRACTION_BITS_DEFAULT;

  localparam int N_RANDOM        = 480;
  localparam int HOLD_OFF_CYCLES = 120;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int REPORT_LIMIT    = 10;

  class stat_scoreboard;
    bit                   started;
    bit [TIME_WIDTH-1:0]  start_time;
    bit [TIME_WIDTH-1:0]  current_time;
    bit [CNT_W-1:0]       sent_count;
    bit [CNT_W-1:0]       received_count;
    bit [CNT_W-1:0]       bytes_sent;
    bit [CNT_W-1:0]       bytes_received;
    bit [CNT_W-1:0]       latency_sum;
    bit [JIT_W-1:0]       jitter;
    bit [CNT_W-1:0]       underrun_count;
    bit [CNT_W-1:0]       overrun_count;
    bit [CNT_W-1:0]       outstanding_sum;
    bit [CNT_W-1:0]       outstanding_samples;
    bit [CNT_W-1:0]       fifo_level_sum;
    bit [CNT_W-1:0]       fifo_samples;
    bit [LAT_W-1:0]       prev_latency;
    bit [DATA_WIDTH-1:0]  expected_reads[$];
    int                   op_seen[4];
    int                   checked;
    int                   failures;

    function new();
      start_time = '1;
    endfunction

    function void mark_time(logic [TIME_WIDTH-1:0] t);
      if (!started) begin
        started = 1'b1;
        start_time = t;
      end
      // time never moves backward
      if (t >= current_time) current_time = t;
    endfunction

    function void note_item(item_t it);
      bit [LAT_W-1:0]      lat;
      bit [LAT_W-1:0]      delta;
      bit [JIT_W-1:0]      target;
      bit [DATA_WIDTH-1:0] value;
      op_seen[it.operation]++;
      case (it.operation)
        OP_SEND: begin
          mark_time(it.timestamp);
          sent_count += 1;
          bytes_sent += it.byte_count;
          outstanding_sum += it.outstanding;
          outstanding_samples += 1;
        end
        OP_RECEIVE: begin
          mark_time(it.timestamp);
          received_count += 1;
          bytes_received += it.byte_count;
          lat = it.response_latency[LAT_W-1:0];
          delta = (lat >= prev_latency) ? lat - prev_latency : prev_latency - lat;
          target = JIT_W'(delta) << JITTER_FRACTION_BITS_DEFAULT;
          // round toward the lower value in both directions
          if (target >= jitter)
            jitter = jitter + ((target - jitter) >> JITTER_GAIN_SHIFT);
          else
            jitter = jitter - ((jitter - target + JIT_W'((1 << JITTER_GAIN_SHIFT) - 1))
                               >> JITTER_GAIN_SHIFT);
          prev_latency = lat;
          latency_sum += lat;
        end
        OP_FIFO_SAMPLE: begin
          fifo_level_sum += it.fifo_level;
          fifo_samples += 1;
          if (it.underrun_flag) underrun_count += 1;
          if (it.overrun_flag) overrun_count += 1;
        end
        default: begin
          case (it.counter_index)
            IDX_STARTED:             value = DATA_WIDTH'(started);
            IDX_START_TIME:          value = start_time;
            IDX_CURRENT_TIME:        value = current_time;
            IDX_SENT_COUNT:          value = sent_count;
            IDX_RECEIVED_COUNT:      value = received_count;
            IDX_BYTES_SENT:          value = bytes_sent;
            IDX_BYTES_RECEIVED:      value = bytes_received;
            IDX_LATENCY_SUM:         value = latency_sum;
            IDX_JITTER_ESTIMATE:     value = DATA_WIDTH'(jitter);
            IDX_UNDERRUN_COUNT:      value = underrun_count;
            IDX_OVERRUN_COUNT:       value = overrun_count;
            IDX_OUTSTANDING_SUM:     value = outstanding_sum;
            IDX_OUTSTANDING_SAMPLES: value = outstanding_samples;
            IDX_FIFO_LEVEL_SUM:      value = fifo_level_sum;
            IDX_FIFO_SAMPLES:        value = fifo_samples;
            default:                 value = DATA_WIDTH'(prev_latency);
          endcase
          expected_reads.push_back(value);
        end
      endcase
    endfunction

    function void check_result(logic [DATA_WIDTH-1:0] got);
      bit [DATA_WIDTH-1:0] want;
      if (expected_reads.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("%0t: unexpected result transfer, read_data=%h", $realtime, got);
        return;
      end
      want = expected_reads.pop_front();
      checked++;
      if (got !== want) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("%0t: read %0d mismatch, expected read_data=%h, got %h",
                   $realtime, checked, want, got);
      end
    endfunction

    function int pending();
      return expected_reads.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   hold_off_req;
  bit   hold_off_active;
  int   idle_cycles;

  stat_scoreboard board;

  tsm_item_if   item_bus ();
  tsm_result_if result_bus ();

  traffic_statistics_monitor_unit DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item_bus),
    .result (result_bus)
  );

  always #5 clk = ~clk;

  function automatic item_t random_fields();
    item_t it;
    it.operation        = op_t'($urandom_range(0, 3));
    it.timestamp        = {$urandom, $urandom};
    it.byte_count       = $urandom;
    it.outstanding      = LEVEL_WIDTH'($urandom);
    it.response_latency = $urandom;
    it.fifo_level       = LEVEL_WIDTH'($urandom);
    it.underrun_flag    = 1'($urandom_range(0, 1));
    it.overrun_flag     = 1'($urandom_range(0, 1));
    it.counter_index    = index_t'($urandom_range(0, 15));
    return it;
  endfunction

  function automatic item_t make_event(op_t op, logic [TIME_WIDTH-1:0] ts,
                                       logic [LAT_IN_WIDTH-1:0] lat, index_t idx);
    item_t it;
    it = random_fields();
    it.operation        = op;
    it.timestamp        = ts;
    it.response_latency = lat;
    it.counter_index    = idx;
    return it;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic drive_bus(input item_t it, input logic v);
    item_bus.valid            <= v;
    item_bus.operation        <= it.operation;
    item_bus.timestamp        <= it.timestamp;
    item_bus.byte_count       <= it.byte_count;
    item_bus.outstanding      <= it.outstanding;
    item_bus.response_latency <= it.response_latency;
    item_bus.fifo_level       <= it.fifo_level;
    item_bus.underrun_flag    <= it.underrun_flag;
    item_bus.overrun_flag     <= it.overrun_flag;
    item_bus.counter_index    <= it.counter_index;
  endtask

  // drop valid and put junk on the payload
  task automatic idle_bus(input int n);
    @(negedge clk);
    drive_bus(random_fields(), 1'b0);
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic push_item(input item_t it, input int gap);
    @(negedge clk);
    drive_bus(it, 1'b1);
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
    if (gap > 0) idle_bus(gap);
  endtask

  // note inputs before checking results so a same-edge result still finds its entry
  always @(posedge clk) begin : transfer_monitor
    item_t seen;
    if (!rst) begin
      if (item_bus.valid && item_bus.ready) begin
        seen.operation        = item_bus.operation;
        seen.timestamp        = item_bus.timestamp;
        seen.byte_count       = item_bus.byte_count;
        seen.outstanding      = item_bus.outstanding;
        seen.response_latency = item_bus.response_latency;
        seen.fifo_level       = item_bus.fifo_level;
        seen.underrun_flag    = item_bus.underrun_flag;
        seen.overrun_flag     = item_bus.overrun_flag;
        seen.counter_index    = index_t'(item_bus.counter_index);
        board.note_item(seen);
      end
      if (result_bus.valid && result_bus.ready)
        board.check_result(result_bus.read_data);
    end
    if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d reads outstanding",
               $realtime, idle_cycles, board.pending());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : result_receiver
    int r;
    int len;
    logic level;
    result_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        result_bus.ready <= 1'b0;
        hold_off_active = 1'b1;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
        hold_off_active = 1'b0;
        hold_off_req = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          level = 1'b1;
          len = $urandom_range(1, 40);
        end else if (r < 95) begin
          level = 1'b0;
          len = $urandom_range(1, 3);
        end else begin
          level = 1'b0;
          len = $urandom_range(15, 50);
        end
        result_bus.ready <= level;
        repeat (len - 1) @(negedge clk);
      end
    end
  end

  initial begin : item_sender
    item_t                 it;
    int                    r;
    logic [TIME_WIDTH-1:0] time_cursor;
    board = new();
    clk = 1'b0;
    rst = 1'b1;
    idle_cycles = 0;
    hold_off_req = 1'b0;
    hold_off_active = 1'b0;
    drive_bus(make_event(OP_SEND, '0, '0, IDX_STARTED), 1'b0);
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reads at reset, FIFO samples that must not start the clock
    push_item(make_event(OP_READ, '0, '0, IDX_STARTED), pick_gap());
    push_item(make_event(OP_READ, '0, '0, IDX_START_TIME), pick_gap());
    it = make_event(OP_FIFO_SAMPLE, '1, '1, IDX_PREVIOUS_LATENCY);
    it.fifo_level = '1;
    it.underrun_flag = 1'b1;
    it.overrun_flag = 1'b1;
    push_item(it, 0);
    it.fifo_level = '0;
    it.overrun_flag = 1'b0;
    push_item(it, 0);
    it.underrun_flag = 1'b0;
    it.overrun_flag = 1'b1;
    push_item(it, pick_gap());
    push_item(make_event(OP_READ, '0, '0, IDX_STARTED), 0);

    // first send at time zero starts the clock
    it = make_event(OP_SEND, '0, '0, IDX_STARTED);
    it.byte_count = '1;
    it.outstanding = '1;
    push_item(it, 0);
    push_item(make_event(OP_READ, '0, '0, IDX_START_TIME), pick_gap());
    it = make_event(OP_SEND, 1000, '0, IDX_STARTED);
    it.byte_count = '0;
    it.outstanding = '0;
    push_item(it, 0);

    // backward timestamp, then full-scale latency swings in both directions
    it = make_event(OP_RECEIVE, 400, '1, IDX_STARTED);
    it.byte_count = '1;
    push_item(it, 0);
    push_item(make_event(OP_READ, '0, '0, IDX_CURRENT_TIME), 0);
    it = make_event(OP_RECEIVE, 1000, '0, IDX_STARTED);
    it.byte_count = '0;
    push_item(it, pick_gap());
    push_item(make_event(OP_READ, '0, '0, IDX_JITTER_ESTIMATE), 0);
    push_item(make_event(OP_RECEIVE, 1500, '0, IDX_STARTED), 0);
    push_item(make_event(OP_RECEIVE, 1600, '0, IDX_STARTED), 0);
    push_item(make_event(OP_READ, '0, '0, IDX_JITTER_ESTIMATE), 0);
    push_item(make_event(OP_READ, '0, '0, IDX_PREVIOUS_LATENCY), pick_gap());
    push_item(make_event(OP_READ, '0, '0, IDX_LATENCY_SUM), 0);
    push_item(make_event(OP_READ, '0, '0, IDX_FIFO_LEVEL_SUM), 0);
    push_item(make_event(OP_READ, '0, '0, IDX_UNDERRUN_COUNT), 0);
    push_item(make_event(OP_READ, '0, '0, IDX_OVERRUN_COUNT), 0);
    push_item(make_event(OP_READ, '0, '0, IDX_OUTSTANDING_SUM), pick_gap());
    time_cursor = 1600;

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 2) begin
        // stall the result side and keep offering reads until the input backs up
        idle_bus(1);
        hold_off_req = 1'b1;
        wait (hold_off_active);
        repeat (12) push_item(make_event(OP_READ, '0, '0, index_t'($urandom_range(0, 15))), 0);
      end
      it = random_fields();
      r = $urandom_range(0, 99);
      if (r < 25) it.operation = OP_SEND;
      else if (r < 50) it.operation = OP_RECEIVE;
      else if (r < 70) it.operation = OP_FIFO_SAMPLE;
      else it.operation = OP_READ;
      if (it.operation == OP_SEND || it.operation == OP_RECEIVE) begin
        r = $urandom_range(0, 99);
        if (r < 10 && time_cursor > 5000) begin
          it.timestamp = time_cursor - $urandom_range(1, 5000);
        end else begin
          time_cursor += $urandom_range(0, 200);
          it.timestamp = time_cursor;
        end
        if ($urandom_range(0, 99) < 70) it.response_latency = $urandom_range(200, 600);
      end
      push_item(it, ((i % 128) < 32) ? 0 : pick_gap());
    end

    // largest timestamp, then an older one that must not pull time back
    push_item(make_event(OP_SEND, '1, '0, IDX_STARTED), 0);
    push_item(make_event(OP_READ, '0, '0, IDX_CURRENT_TIME), 0);
    push_item(make_event(OP_RECEIVE, time_cursor, '1, IDX_STARTED), 0);
    push_item(make_event(OP_READ, '0, '0, IDX_CURRENT_TIME), 0);
    push_item(make_event(OP_READ, '0, '0, IDX_START_TIME), 0);
    idle_bus(1);

    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d sends, %0d receives, %0d FIFO samples and %0d counter reads",
             board.op_seen[OP_SEND], board.op_seen[OP_RECEIVE],
             board.op_seen[OP_FIFO_SAMPLE], board.op_seen[OP_READ]);
    $display("%0d read results compared, %0d failures", board.checked, board.failures);
    if (board.failures == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
